>>> rtl/core/bcm_lcg_pkg.sv
// Shared types and constants of the line control generator.
package bcm_lcg_pkg;

    localparam int unsigned MAX_PLANES = 12;
    localparam int unsigned MAX_ROWS   = 32;

    localparam int unsigned ROW_W   = 5;
    localparam int unsigned PLANE_W = 4;
    localparam int unsigned COL_W   = 12;
    localparam int unsigned LINE_W  = 9;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned GUARD_W = 8;
    localparam int unsigned RCNT_W  = 6;
    localparam int unsigned BRT_W   = 8;

    // Display extension is a 12-bit span shifted left by up to 13 places.
    localparam int unsigned EXT_W = 26;
    localparam int unsigned SUM_W = EXT_W + 1;
    localparam int unsigned RS_W  = 5;
    localparam int unsigned SGN_W = 7;

    localparam logic [LEN_W-1:0] LINE_MAX          = 12'd4095;
    localparam int unsigned      SETTLE_COLS       = 2;
    localparam int unsigned      BRIGHT_STEP_SHIFT = 4;

    localparam logic [CFG_W-1:0]   SHIFT_WIDTH_RST = 12'd64;
    localparam logic [GUARD_W-1:0] LATCH_GUARD_RST = 8'd1;
    localparam logic [3:0]         TRANS_PLANE_RST = 4'd0;
    localparam logic [3:0]         PLANE_CNT_RST   = 4'd8;
    localparam logic [RCNT_W-1:0]  ROW_CNT_RST     = 6'd16;
    localparam logic [BRT_W-1:0]   BRIGHTNESS_RST  = 8'd128;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SHIFT_WIDTH      = 3'd0,
        CFG_LATCH_GUARD      = 3'd1,
        CFG_TRANSITION_PLANE = 3'd2,
        CFG_PLANE_COUNT      = 3'd3,
        CFG_ROW_COUNT        = 3'd4,
        CFG_BRIGHTNESS       = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0]   scan_row;
        logic [PLANE_W-1:0] plane;
        logic [COL_W-1:0]   column;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_address;
        logic              display_enable;
        logic              in_shift_section;
        logic [LINE_W-1:0] line_number;
        logic [LEN_W-1:0]  line_length;
    } out_t;

endpackage

>>> rtl/core/bcm_line_control_generator_core.sv
// Top level of the HUB75 line control generator: five-stage column pipeline.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    scan_row, plane, column
//   m_        out        m_valid / m_ready    row_address, display_enable,
//                                             in_shift_section, line_number,
//                                             line_length
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// A transfer enters stage one at acceptance and passes stages two to four to
// the result register; one transfer can enter in every cycle unless the result
// side stalls, as the shift, add, multiply and window arithmetic spans the five stages.
// Reset is synchronous and active low: it clears the valid bits and loads the
// reset values into the configuration registers. A result-side stall holds
// occupied stages in place while empty stages still advance, losing nothing.
module bcm_line_control_generator_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  bcm_lcg_pkg::in_t                        s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output bcm_lcg_pkg::out_t                       m_data,
    input  logic                                    cfg_wr_en,
    input  logic [bcm_lcg_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [bcm_lcg_pkg::CFG_W-1:0]           cfg_wdata
);
    import bcm_lcg_pkg::*;

    // Stage one: previous line, display extensions and right-shift count.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  back_row;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line_num;
        logic              le_tp;
        logic [RS_W-1:0]   rs;
        logic              min_hit;
        logic [EXT_W-1:0]  ext;
        logic [EXT_W-1:0]  ext_last;
    } st1_t;

    // Stage two: line length and maximum lit width.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  back_row;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line_num;
        logic              min_hit;
        logic [EXT_W-1:0]  ext;
        logic [LEN_W-1:0]  len;
        logic [EXT_W-1:0]  maxd;
        logic              kill;
    } st2_t;

    // Stage three: brightness product and column region.
    typedef struct packed {
        logic [ROW_W-1:0]  addr;
        logic              shift;
        logic              main;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line_num;
        logic              min_hit;
        logic [EXT_W-1:0]  ext;
        logic [LEN_W-1:0]  len;
        logic [EXT_W-1:0]  maxd;
        logic              kill;
        logic [EXT_W-1:0]  dc_raw;
    } st3_t;

    // Stage four: clamped on-time and window start.
    typedef struct packed {
        logic [ROW_W-1:0]  addr;
        logic              shift;
        logic              main;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line_num;
        logic [EXT_W-1:0]  ext;
        logic [LEN_W-1:0]  len;
        logic              kill;
        logic [EXT_W-1:0]  start;
        logic [EXT_W-1:0]  dc1;
    } st4_t;

    // Extra display time of a plane beyond the guard.
    function automatic logic [EXT_W-1:0] ext_of(input logic [PLANE_W-1:0] b,
                                                input logic [PLANE_W-1:0] t,
                                                input logic [CFG_W-1:0]   dv);
        logic [PLANE_W-1:0] sh;
        sh = b - t - PLANE_W'(1);
        if (b <= t) begin
            return EXT_W'(dv);
        end
        return EXT_W'(dv) << sh;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0]   shift_width_reg;
    logic [GUARD_W-1:0] latch_guard_reg;
    logic [3:0]         trans_plane_reg;
    logic [3:0]         plane_count_reg;
    logic [RCNT_W-1:0]  row_count_reg;
    logic [BRT_W-1:0]   brightness_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_width_reg <= SHIFT_WIDTH_RST;
            latch_guard_reg <= LATCH_GUARD_RST;
            trans_plane_reg <= TRANS_PLANE_RST;
            plane_count_reg <= PLANE_CNT_RST;
            row_count_reg   <= ROW_CNT_RST;
            brightness_reg  <= BRIGHTNESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHIFT_WIDTH:      shift_width_reg <= cfg_wdata;
                CFG_LATCH_GUARD:      latch_guard_reg <= cfg_wdata[GUARD_W-1:0];
                CFG_TRANSITION_PLANE: trans_plane_reg <= cfg_wdata[3:0];
                CFG_PLANE_COUNT:      plane_count_reg <= cfg_wdata[3:0];
                CFG_ROW_COUNT:        row_count_reg   <= cfg_wdata[RCNT_W-1:0];
                CFG_BRIGHTNESS:       brightness_reg  <= cfg_wdata[BRT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Values that follow from configuration alone. The user must change them only
    // while the pipeline is empty (not enforced here); every stage reads them directly.
    logic [PLANE_W-1:0] pn;
    logic [RCNT_W-1:0]  rn;
    logic [ROW_W-1:0]   rn_last;
    logic [CFG_W-1:0]   span;

    always_comb begin
        if (plane_count_reg == '0) begin
            pn = PLANE_W'(1);
        end else if (plane_count_reg > PLANE_W'(MAX_PLANES)) begin
            pn = PLANE_W'(MAX_PLANES);
        end else begin
            pn = plane_count_reg;
        end
        if (row_count_reg == '0) begin
            rn = RCNT_W'(1);
        end else if (row_count_reg > RCNT_W'(MAX_ROWS)) begin
            rn = RCNT_W'(MAX_ROWS);
        end else begin
            rn = row_count_reg;
        end
        rn_last = ROW_W'(rn - RCNT_W'(1));
        // The lit span shrinks to nothing when the guard covers the shift width.
        if (shift_width_reg > CFG_W'(latch_guard_reg)) begin
            span = shift_width_reg - CFG_W'(latch_guard_reg);
        end else begin
            span = '0;
        end
    end

    // Handshake: each stage takes a new item when it is empty or when its
    // own item moves on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    out_t out_reg, out_next;

    // Stage one. Plane zero shows the last plane of the row before, with
    // wrap from the first row to the last one.
    logic [PLANE_W-1:0]     prev_plane;
    logic signed [SGN_W-1:0] a_s, h_s, rs_s, minb_s;

    always_comb begin
        st1_next     = st1_reg;
        st1_next.row = s_data.scan_row;
        st1_next.col = s_data.column;
        if (s_data.plane == '0) begin
            prev_plane = pn - PLANE_W'(1);
            if (s_data.scan_row == '0) begin
                st1_next.back_row = rn_last;
            end else begin
                st1_next.back_row = s_data.scan_row - ROW_W'(1);
            end
        end else begin
            prev_plane        = s_data.plane - PLANE_W'(1);
            st1_next.back_row = s_data.scan_row;
        end
        st1_next.line_num = LINE_W'(({5'b0, s_data.scan_row} * {6'b0, pn})
                                    + {6'b0, s_data.plane});
        st1_next.le_tp    = prev_plane <= trans_plane_reg;
        st1_next.ext      = ext_of(prev_plane, trans_plane_reg, span);
        // Extensions grow with the plane, so the last plane sets the line.
        st1_next.ext_last = ext_of(pn - PLANE_W'(1), trans_plane_reg, span);
        // Right shift for shortened planes; the halving rounds toward minus
        // infinity, which an arithmetic shift gives directly.
        a_s  = $signed({3'b0, pn}) - SGN_W'(1) - $signed({3'b0, prev_plane});
        h_s  = ($signed({3'b0, pn}) - $signed({3'b0, trans_plane_reg}) - SGN_W'(1)) >>> 1;
        rs_s = a_s - h_s - SGN_W'(2);
        if (rs_s < 0) begin
            st1_next.rs = '0;
        end else begin
            st1_next.rs = rs_s[RS_W-1:0];
        end
        // Low planes get at least one lit column once brightness reaches them.
        minb_s = $signed({3'b0, pn}) - SGN_W'(1)
                 - $signed({3'b0, brightness_reg[BRT_W-1:BRIGHT_STEP_SHIFT]});
        st1_next.min_hit = $signed({3'b0, prev_plane}) >= minb_s;
    end

    // Stage two.
    logic [SUM_W-1:0] tot, tot_even;

    always_comb begin
        st2_next          = st2_reg;
        st2_next.row      = st1_reg.row;
        st2_next.back_row = st1_reg.back_row;
        st2_next.col      = st1_reg.col;
        st2_next.line_num = st1_reg.line_num;
        st2_next.min_hit  = st1_reg.min_hit;
        st2_next.ext      = st1_reg.ext;
        tot      = SUM_W'(shift_width_reg) + SUM_W'(latch_guard_reg)
                   + SUM_W'(st1_reg.ext_last);
        tot_even = tot + SUM_W'(tot[0]);
        if (tot_even > SUM_W'(LINE_MAX)) begin
            st2_next.len = LINE_MAX;
        end else begin
            st2_next.len = tot_even[LEN_W-1:0];
        end
        if (st1_reg.le_tp) begin
            st2_next.maxd = st1_reg.ext >> st1_reg.rs;
        end else begin
            st2_next.maxd = st1_reg.ext;
        end
        st2_next.kill = (brightness_reg == '0) || (st1_reg.ext < EXT_W'(2))
                        || (st2_next.maxd < EXT_W'(2));
    end

    // Stage three.
    logic [EXT_W+BRT_W-1:0] prod;
    logic [LEN_W-1:0]       scol;
    logic                   past;

    always_comb begin
        st3_next          = st3_reg;
        st3_next.col      = st2_reg.col;
        st3_next.line_num = st2_reg.line_num;
        st3_next.min_hit  = st2_reg.min_hit;
        st3_next.ext      = st2_reg.ext;
        st3_next.len      = st2_reg.len;
        st3_next.maxd     = st2_reg.maxd;
        st3_next.kill     = st2_reg.kill;
        prod              = st2_reg.maxd * brightness_reg;
        st3_next.dc_raw   = prod[EXT_W+BRT_W-1:BRT_W];
        // The saturated length never falls below the shift width.
        scol              = st2_reg.len - shift_width_reg;
        past              = st2_reg.col >= st2_reg.len;
        st3_next.shift    = !past && (st2_reg.col >= scol);
        st3_next.main     = !past && !(st2_reg.col >= scol);
        if (st3_next.main && (EXT_W'(st2_reg.col) < st2_reg.ext)) begin
            st3_next.addr = st2_reg.back_row;
        end else begin
            st3_next.addr = st2_reg.row;
        end
    end

    // Stage four.
    logic [EXT_W-1:0] dc0, start0;

    always_comb begin
        st4_next          = st4_reg;
        st4_next.addr     = st3_reg.addr;
        st4_next.shift    = st3_reg.shift;
        st4_next.main     = st3_reg.main;
        st4_next.col      = st3_reg.col;
        st4_next.line_num = st3_reg.line_num;
        st4_next.ext      = st3_reg.ext;
        st4_next.len      = st3_reg.len;
        st4_next.kill     = st3_reg.kill;
        if ((st3_reg.dc_raw == '0) && st3_reg.min_hit) begin
            dc0 = EXT_W'(1);
        end else begin
            dc0 = st3_reg.dc_raw;
        end
        if (dc0 > st3_reg.maxd - EXT_W'(1)) begin
            st4_next.dc1 = st3_reg.maxd - EXT_W'(1);
        end else begin
            st4_next.dc1 = dc0;
        end
        // Center the window, but keep it clear of the settling columns.
        start0 = (st3_reg.ext - st4_next.dc1) >> 1;
        if (start0 < EXT_W'(SETTLE_COLS)) begin
            st4_next.start = EXT_W'(SETTLE_COLS);
        end else begin
            st4_next.start = start0;
        end
    end

    // Stage five: trim the window to the available time and test the column.
    logic [SUM_W-1:0] win_end;
    logic [EXT_W-1:0] dc2;

    always_comb begin
        win_end = SUM_W'(st4_reg.start) + SUM_W'(st4_reg.dc1);
        if (win_end > SUM_W'(st4_reg.ext)) begin
            dc2 = st4_reg.ext - st4_reg.start;
        end else begin
            dc2 = st4_reg.dc1;
        end
        out_next.row_address      = st4_reg.addr;
        out_next.display_enable   = st4_reg.main && !st4_reg.kill && (dc2 != '0)
                                    && (EXT_W'(st4_reg.col) >= st4_reg.start)
                                    && (SUM_W'(st4_reg.col)
                                        < SUM_W'(st4_reg.start) + SUM_W'(dc2));
        out_next.in_shift_section = st4_reg.shift;
        out_next.line_number      = st4_reg.line_num;
        out_next.line_length      = st4_reg.len;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            st1_reg <= st1_next;
        end
        if (rdy2) begin
            st2_reg <= st2_next;
        end
        if (rdy3) begin
            st3_reg <= st3_next;
        end
        if (rdy4) begin
            st4_reg <= st4_next;
        end
        if (rdy5) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule
